FILE: rtl/core/mstl_pkg.sv
package mstl_pkg;

  localparam int unsigned CountW   = 6;
  localparam int unsigned IndexW   = 5;
  localparam int unsigned DimW     = 16;
  localparam int unsigned PadW     = 10;
  localparam int unsigned McW      = 8;
  localparam int unsigned RatioW   = 16;
  localparam int unsigned SerialW  = 32;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned DefMaxViews = 32;

  localparam logic [RatioW-1:0] RatioMin   = 16'd6554;
  localparam logic [RatioW-1:0] RatioMax   = 16'd58982;
  localparam logic [RatioW-1:0] RatioReset = 16'd39322;
  localparam logic [McW-1:0]    MainCountReset = 8'd1;
  localparam logic [PadW-1:0]   ViewPadReset   = 10'd5;
  localparam logic [PadW-1:0]   OuterPadReset  = 10'd5;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAIN_COUNT    = 8'd0,
    CFG_MAIN_RATIO    = 8'd1,
    CFG_VIEW_PADDING  = 8'd2,
    CFG_OUTER_PADDING = 8'd3
  } mstl_cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIVM,
    S_DIVS,
    S_EMIT
  } mstl_state_e;

  typedef struct packed {
    logic [CountW-1:0]  num_views;
    logic [DimW-1:0]    screen_width;
    logic [DimW-1:0]    screen_height;
    logic [SerialW-1:0] request_serial;
  } mstl_req_t;

  typedef struct packed {
    logic [IndexW-1:0]  view_index;
    logic [DimW-1:0]    pos_x;
    logic [DimW-1:0]    pos_y;
    logic [DimW-1:0]    rect_width;
    logic [DimW-1:0]    rect_height;
    logic [SerialW-1:0] result_serial;
    logic               last_view;
  } mstl_rect_t;

  typedef struct packed {
    logic              start;
    logic [DimW-1:0]   dividend;
    logic [CountW-1:0] divisor;
  } mstl_div_req_t;

  typedef struct packed {
    logic            done;
    logic [DimW-1:0] quotient;
  } mstl_div_rsp_t;

endpackage

FILE: rtl/core/mstl_div.sv
module mstl_div import mstl_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mstl_div_req_t req_i,
  output mstl_div_rsp_t rsp_o
);

  localparam int unsigned StepW = $clog2(DimW);
  localparam logic [StepW-1:0] LastStep = StepW'(DimW - 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [DimW-1:0]   work_q, work_d;
  logic [CountW-1:0] rem_q, rem_d;
  logic [CountW-1:0] dvs_q, dvs_d;

  logic [CountW:0]   rem_sh;
  logic [CountW:0]   rem_nx;
  logic              ge;

  // restoring division, one quotient bit per cycle; quotient shifts into work_q
  always_comb begin
    rem_sh = {rem_q, work_q[DimW-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_nx = ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    work_d = work_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      work_d = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      work_d = {work_q[DimW-2:0], ge};
      rem_d  = rem_nx[CountW-1:0];
      step_d = step_q + 1'b1;
      if (step_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = work_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("divider done without a running division");

  a_no_restart_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !req_i.start) |=> (busy_q || done_q))
    else $error("divider stopped without done");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && dvs_q != '0) |-> (rem_q < dvs_q))
    else $error("partial remainder not below divisor");

endmodule

FILE: rtl/core/master_stack_tile_layout.sv
// channel   direction  handshake             payload
// in        input      in_valid_i/in_stall_o  mstl_req_t (view count, screen size, serial)
// out       output     out_valid_o/out_stall_i mstl_rect_t (one rectangle per view)
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// a request is latched, the ratio multiply runs, then two passes go through the
// shared bit-serial divider, then one rectangle per cycle is emitted while the
// output is not stalled.
// a request with zero views is accepted and yields nothing.
// reset is asynchronous; only control and config registers are reset, at once.
// a stalled output holds its rectangle; input stays stalled until the last one is loaded.
module master_stack_tile_layout import mstl_pkg::*; #(
  parameter int unsigned MAX_VIEWS = DefMaxViews
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mstl_req_t           in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mstl_rect_t          out_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam logic [McW-1:0] MaxViewsW = McW'(MAX_VIEWS);

  mstl_state_e state_q, state_d;

  logic [McW-1:0]    main_count_q;
  logic [RatioW-1:0] ratio_q;
  logic [PadW-1:0]   vpad_q;
  logic [PadW-1:0]   opad_q;

  logic [CountW-1:0]  n_q, n_d;
  logic [DimW-1:0]    w_q, w_d;
  logic [DimW-1:0]    h_q, h_d;
  logic [SerialW-1:0] serial_q, serial_d;
  logic [DimW-1:0]    main_w_q, main_w_d;
  logic [DimW-1:0]    q_main_q, q_main_d;
  logic [DimW-1:0]    q_stack_q, q_stack_d;
  logic [CountW-1:0]  i_q, i_d;
  logic [DimW-1:0]    y_q, y_d;
  mstl_rect_t         out_q, out_d;
  logic               out_valid_q, out_valid_d;

  mstl_div_req_t div_req;
  mstl_div_rsp_t div_rsp;

  logic                in_acc, cfg_acc, out_free, emit, last;
  logic [CountW-1:0]   n_in;
  logic [PadW:0]       two_op, two_vp;
  logic [DimW-1:0]     sw_sat, sh_sat;
  logic [CountW-1:0]   cnt_main, cnt_stack;
  logic                stack_used;
  logic [2*DimW-1:0]   product;
  logic [DimW-1:0]     main_w_calc;
  logic                is_main, at_split;
  logic [DimW-1:0]     vx, vy, vw, vh;
  logic [DimW:0]       pad_sum, px, py;
  logic [RatioW-1:0]   ratio_wr;

  mstl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign emit        = (state_q == S_EMIT) && out_free;
  assign last        = ({1'b0, i_q} + 1'b1) == {1'b0, n_q};

  // request setup arithmetic
  always_comb begin
    n_in   = ({2'b0, in_i.num_views} > MaxViewsW) ? MaxViewsW[CountW-1:0]
                                                  : in_i.num_views;
    two_op = {opad_q, 1'b0};
    two_vp = {vpad_q, 1'b0};
    sw_sat = (in_i.screen_width > DimW'(two_op))
           ? in_i.screen_width - DimW'(two_op) : '0;
    sh_sat = (in_i.screen_height > DimW'(two_op))
           ? in_i.screen_height - DimW'(two_op) : '0;
    stack_used = {2'b0, n_q} > main_count_q;
    cnt_main   = stack_used ? main_count_q[CountW-1:0] : n_q;
    cnt_stack  = stack_used ? n_q - main_count_q[CountW-1:0] : '0;
    product    = w_q * ratio_q;
    if (main_count_q == '0) begin
      main_w_calc = '0;
    end else if (!stack_used) begin
      main_w_calc = w_q;
    end else begin
      main_w_calc = product[2*DimW-1:RatioW];
    end
  end

  // unused columns divide by one to keep the divider well defined
  always_comb begin
    div_req.dividend = h_q;
    div_req.start    = (state_q == S_MUL) || ((state_q == S_DIVM) && div_rsp.done);
    if (state_q == S_MUL) begin
      div_req.divisor = (cnt_main == '0) ? CountW'(1) : cnt_main;
    end else begin
      div_req.divisor = (cnt_stack == '0) ? CountW'(1) : cnt_stack;
    end
  end

  // rectangle for view i_q
  always_comb begin
    is_main  = {2'b0, i_q} < main_count_q;
    at_split = {2'b0, i_q} == main_count_q;
    vy       = at_split ? '0 : y_q;
    vh       = is_main ? q_main_q : q_stack_q;
    vx       = is_main ? '0 : main_w_q;
    vw       = is_main ? main_w_q : w_q - main_w_q;
    pad_sum  = {7'b0, vpad_q} + {7'b0, opad_q};
    px       = {1'b0, vx} + pad_sum;
    py       = {1'b0, vy} + pad_sum;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && n_in != '0) state_d = S_MUL;
      end
      S_MUL:  state_d = S_DIVM;
      S_DIVM: begin
        if (div_rsp.done) state_d = S_DIVS;
      end
      S_DIVS: begin
        if (div_rsp.done) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (emit && last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    n_d         = n_q;
    w_d         = w_q;
    h_d         = h_q;
    serial_d    = serial_q;
    main_w_d    = main_w_q;
    q_main_d    = q_main_q;
    q_stack_d   = q_stack_q;
    i_d         = i_q;
    y_d         = y_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          n_d      = n_in;
          w_d      = sw_sat;
          h_d      = sh_sat;
          serial_d = in_i.request_serial;
          i_d      = '0;
          y_d      = '0;
        end
      end
      S_MUL:  main_w_d = main_w_calc;
      S_DIVM: begin
        if (div_rsp.done) q_main_d = div_rsp.quotient;
      end
      S_DIVS: begin
        if (div_rsp.done) q_stack_d = div_rsp.quotient;
      end
      S_EMIT: begin
        if (emit) begin
          out_valid_d         = 1'b1;
          out_d.view_index    = i_q[IndexW-1:0];
          out_d.pos_x         = px[DimW] ? '1 : px[DimW-1:0];
          out_d.pos_y         = py[DimW] ? '1 : py[DimW-1:0];
          out_d.rect_width    = (vw > DimW'(two_vp)) ? vw - DimW'(two_vp) : '0;
          out_d.rect_height   = (vh > DimW'(two_vp)) ? vh - DimW'(two_vp) : '0;
          out_d.result_serial = serial_q;
          out_d.last_view     = last;
          i_d                 = i_q + 1'b1;
          y_d                 = vy + vh;
        end
      end
      default: ;
    endcase
  end

  // ratio is clamped when written
  always_comb begin
    if (cfg_data_i < RatioMin) begin
      ratio_wr = RatioMin;
    end else if (cfg_data_i > RatioMax) begin
      ratio_wr = RatioMax;
    end else begin
      ratio_wr = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_count_q <= MainCountReset;
      ratio_q      <= RatioReset;
      vpad_q       <= ViewPadReset;
      opad_q       <= OuterPadReset;
    end else if (cfg_acc) begin
      case (cfg_index_i)
        CFG_MAIN_COUNT:    main_count_q <= cfg_data_i[McW-1:0];
        CFG_MAIN_RATIO:    ratio_q      <= ratio_wr;
        CFG_VIEW_PADDING:  vpad_q       <= cfg_data_i[PadW-1:0];
        CFG_OUTER_PADDING: opad_q       <= cfg_data_i[PadW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      i_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      i_q         <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    w_q       <= w_d;
    h_q       <= h_d;
    serial_q  <= serial_d;
    main_w_q  <= main_w_d;
    q_main_q  <= q_main_d;
    q_stack_q <= q_stack_d;
    y_q       <= y_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (i_q < n_q))
    else $error("view index past view count");

  a_last_ends_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last) |=> (state_q == S_IDLE) && out_valid_o && out_o.last_view)
    else $error("last rectangle did not end the request");

  a_ratio_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ratio_q >= RatioMin) && (ratio_q <= RatioMax))
    else $error("main ratio outside clamp range");

  a_no_emit_during_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DIVM) || (state_q == S_DIVS)) |=> !($rose(out_valid_o)))
    else $error("rectangle produced before heights were ready");

endmodule
